/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while in reset.
`define ATOT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while in reset.
`define ATOT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hw/rtl/atot_pkg.sv */
// Types, widths and register indexes for the box / triangle overlap test.
package atot_pkg;

  localparam int CW  = 24;            // coordinate width
  localparam int TW  = 16;            // tag width
  localparam int EW  = CW + 1;        // edge (vertex difference)
  localparam int PRW = EW + CW;       // edge * coordinate
  localparam int ESW = PRW + 1;       // edge-axis projection
  localparam int NPW = 2 * EW;        // edge * edge
  localparam int NW  = NPW + 1;       // normal component
  localparam int NL  = NW / 2;        // low slice of normal, unsigned
  localparam int NH  = NW - NL;       // high slice of normal, signed
  localparam int NLW = NL + 1 + CW;   // low partial product
  localparam int NHW = NH + CW;       // high partial product
  localparam int NFW = NW + CW;       // normal * coordinate
  localparam int NSW = NFW + 2;       // sum of three

  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_BOX_MAX_Z = 3'd5;

  // cyclic component order: for axis c, a = c+1, b = c+2 (mod 3)
  localparam int AX_A [3] = '{1, 2, 0};
  localparam int AX_B [3] = '{2, 0, 1};

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic        [TW-1:0]  tag_t;
  typedef logic signed [EW-1:0]  edge_t;
  typedef logic signed [PRW-1:0] prod_t;
  typedef logic signed [ESW-1:0] esum_t;
  typedef logic signed [NPW-1:0] nprod_t;
  typedef logic signed [NW-1:0]  nrm_t;
  typedef logic signed [NLW-1:0] nlo_t;
  typedef logic signed [NHW-1:0] nhi_t;
  typedef logic signed [NFW-1:0] nfull_t;
  typedef logic signed [NSW-1:0] nsum_t;

  typedef struct packed {
    coord_t vert0_x;
    coord_t vert0_y;
    coord_t vert0_z;
    coord_t vert1_x;
    coord_t vert1_y;
    coord_t vert1_z;
    coord_t vert2_x;
    coord_t vert2_y;
    coord_t vert2_z;
    tag_t   face_tag;
  } in_word_t;

  typedef struct packed {
    logic overlaps;
    tag_t result_tag;
  } out_word_t;

  function automatic edge_t sub_c(coord_t a, coord_t b);
    edge_t ax;
    edge_t bx;
    ax = edge_t'(a);
    bx = edge_t'(b);
    return ax - bx;
  endfunction

  function automatic prod_t mul_ec(edge_t a, coord_t b);
    prod_t ax;
    prod_t bx;
    ax = prod_t'(a);
    bx = prod_t'(b);
    return ax * bx;
  endfunction

  function automatic nprod_t mul_ee(edge_t a, edge_t b);
    nprod_t ax;
    nprod_t bx;
    ax = nprod_t'(a);
    bx = nprod_t'(b);
    return ax * bx;
  endfunction

endpackage

/* hw/rtl/aabb_triangle_overlap_test.sv */
// Top level: box / triangle separating-axis overlap test, 6-stage pipeline.
// Throughput: one triangle per cycle; busy is low whenever out of reset.
// The depth is set by the normal axis: edge*edge products, then normal*coord
// products split into two narrower multiplies, a recombine, and the span sum.
// Reset (sync, active low) clears the six box registers to 0 and all valid
// bits; busy is high while rst_n is low. No stalls: results cannot be held.
`include "assert_macros.svh"
module aabb_triangle_overlap_test (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  atot_pkg::in_word_t               in_word,
  output logic                             out_valid,
  output atot_pkg::out_word_t              out_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [atot_pkg::CFG_IW-1:0]      cfg_index,
  input  atot_pkg::coord_t                 cfg_data
);

  logic in_accept;

  assign busy      = !rst_n;
  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;

  // ---------------------------------------------------------------
  // Box registers. Writes past the last index are dropped.
  // ---------------------------------------------------------------
  atot_pkg::coord_t box_lo_r   [3];
  atot_pkg::coord_t box_hi_r   [3];
  atot_pkg::coord_t box_lo_nxt [3];
  atot_pkg::coord_t box_hi_nxt [3];

  always_comb begin
    box_lo_nxt = box_lo_r;
    box_hi_nxt = box_hi_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        atot_pkg::CFG_BOX_MIN_X: box_lo_nxt[0] = cfg_data;
        atot_pkg::CFG_BOX_MIN_Y: box_lo_nxt[1] = cfg_data;
        atot_pkg::CFG_BOX_MIN_Z: box_lo_nxt[2] = cfg_data;
        atot_pkg::CFG_BOX_MAX_X: box_hi_nxt[0] = cfg_data;
        atot_pkg::CFG_BOX_MAX_Y: box_hi_nxt[1] = cfg_data;
        atot_pkg::CFG_BOX_MAX_Z: box_hi_nxt[2] = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        box_lo_r[c] <= '0;
        box_hi_r[c] <= '0;
      end
    end else begin
      box_lo_r <= box_lo_nxt;
      box_hi_r <= box_hi_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: edges and the three box-axis tests (plain min/max).
  // The box span on an axis is min..max of its two registers, so an
  // inverted box is handled without a swap of the stored values.
  // ---------------------------------------------------------------
  atot_pkg::coord_t vin [3][3];
  atot_pkg::edge_t  ein [3][3];
  logic             box_ok;

  always_comb begin
    atot_pkg::coord_t tmin;
    atot_pkg::coord_t tmax;
    atot_pkg::coord_t bmin;
    atot_pkg::coord_t bmax;
    vin[0] = '{in_word.vert0_x, in_word.vert0_y, in_word.vert0_z};
    vin[1] = '{in_word.vert1_x, in_word.vert1_y, in_word.vert1_z};
    vin[2] = '{in_word.vert2_x, in_word.vert2_y, in_word.vert2_z};
    box_ok = 1'b1;
    for (int c = 0; c < 3; c++) begin
      ein[0][c] = atot_pkg::sub_c(vin[0][c], vin[1][c]);
      ein[1][c] = atot_pkg::sub_c(vin[1][c], vin[2][c]);
      ein[2][c] = atot_pkg::sub_c(vin[2][c], vin[0][c]);
      tmin = vin[0][c];
      tmax = vin[0][c];
      for (int k = 1; k < 3; k++) begin
        if (vin[k][c] < tmin) tmin = vin[k][c];
        if (vin[k][c] > tmax) tmax = vin[k][c];
      end
      bmin = (box_lo_r[c] < box_hi_r[c]) ? box_lo_r[c] : box_hi_r[c];
      bmax = (box_lo_r[c] < box_hi_r[c]) ? box_hi_r[c] : box_lo_r[c];
      if ((tmax < bmin) || (bmax < tmin)) box_ok = 1'b0;
    end
  end

  atot_pkg::coord_t s1_v_r [3][3];
  atot_pkg::edge_t  s1_e_r [3][3];
  logic             s1_box_ok_r;
  atot_pkg::tag_t   s1_tag_r;

  always_ff @(posedge clk) begin
    s1_v_r      <= vin;
    s1_e_r      <= ein;
    s1_box_ok_r <= box_ok;
    s1_tag_r    <= in_word.face_tag;
  end

  // ---------------------------------------------------------------
  // Stage 2: edge-axis products. Axis = edge i x unit j; with
  // a = j+1, b = j+2 the projection of p is e_b*p_a - e_a*p_b.
  // Only two vertices per edge matter: the edge's ends project equal.
  // ---------------------------------------------------------------
  atot_pkg::prod_t s2_tva_r [3][3][2];
  atot_pkg::prod_t s2_tvb_r [3][3][2];
  atot_pkg::prod_t s2_bal_r [3][3];
  atot_pkg::prod_t s2_bah_r [3][3];
  atot_pkg::prod_t s2_bbl_r [3][3];
  atot_pkg::prod_t s2_bbh_r [3][3];
  logic            s2_box_ok_r;
  atot_pkg::tag_t  s2_tag_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s2_tva_r[i][j][0] <= atot_pkg::mul_ec(s1_e_r[i][atot_pkg::AX_B[j]],
                                              s1_v_r[i][atot_pkg::AX_A[j]]);
        s2_tvb_r[i][j][0] <= atot_pkg::mul_ec(s1_e_r[i][atot_pkg::AX_A[j]],
                                              s1_v_r[i][atot_pkg::AX_B[j]]);
        // third vertex of edge i is vertex i+2
        s2_tva_r[i][j][1] <= atot_pkg::mul_ec(s1_e_r[i][atot_pkg::AX_B[j]],
                               s1_v_r[atot_pkg::AX_B[i]][atot_pkg::AX_A[j]]);
        s2_tvb_r[i][j][1] <= atot_pkg::mul_ec(s1_e_r[i][atot_pkg::AX_A[j]],
                               s1_v_r[atot_pkg::AX_B[i]][atot_pkg::AX_B[j]]);
        s2_bal_r[i][j] <= atot_pkg::mul_ec(s1_e_r[i][atot_pkg::AX_B[j]],
                                           box_lo_r[atot_pkg::AX_A[j]]);
        s2_bah_r[i][j] <= atot_pkg::mul_ec(s1_e_r[i][atot_pkg::AX_B[j]],
                                           box_hi_r[atot_pkg::AX_A[j]]);
        s2_bbl_r[i][j] <= atot_pkg::mul_ec(s1_e_r[i][atot_pkg::AX_A[j]],
                                           box_lo_r[atot_pkg::AX_B[j]]);
        s2_bbh_r[i][j] <= atot_pkg::mul_ec(s1_e_r[i][atot_pkg::AX_A[j]],
                                           box_hi_r[atot_pkg::AX_B[j]]);
      end
    end
    s2_box_ok_r <= s1_box_ok_r;
    s2_tag_r    <= s1_tag_r;
  end

  // ---------------------------------------------------------------
  // Stage 3: edge-axis spans and compares. A zero axis gives all
  // zeros and never separates.
  // ---------------------------------------------------------------
  logic edge_ok;

  always_comb begin
    atot_pkg::esum_t t0;
    atot_pkg::esum_t t1;
    atot_pkg::esum_t tmin;
    atot_pkg::esum_t tmax;
    atot_pkg::prod_t amin;
    atot_pkg::prod_t amax;
    atot_pkg::prod_t cmin;
    atot_pkg::prod_t cmax;
    atot_pkg::esum_t bmin;
    atot_pkg::esum_t bmax;
    edge_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        t0   = atot_pkg::esum_t'(s2_tva_r[i][j][0]) - atot_pkg::esum_t'(s2_tvb_r[i][j][0]);
        t1   = atot_pkg::esum_t'(s2_tva_r[i][j][1]) - atot_pkg::esum_t'(s2_tvb_r[i][j][1]);
        tmin = (t0 < t1) ? t0 : t1;
        tmax = (t0 < t1) ? t1 : t0;
        amin = (s2_bal_r[i][j] < s2_bah_r[i][j]) ? s2_bal_r[i][j] : s2_bah_r[i][j];
        amax = (s2_bal_r[i][j] < s2_bah_r[i][j]) ? s2_bah_r[i][j] : s2_bal_r[i][j];
        cmin = (s2_bbl_r[i][j] < s2_bbh_r[i][j]) ? s2_bbl_r[i][j] : s2_bbh_r[i][j];
        cmax = (s2_bbl_r[i][j] < s2_bbh_r[i][j]) ? s2_bbh_r[i][j] : s2_bbl_r[i][j];
        bmin = atot_pkg::esum_t'(amin) - atot_pkg::esum_t'(cmax);
        bmax = atot_pkg::esum_t'(amax) - atot_pkg::esum_t'(cmin);
        if ((tmax < bmin) || (bmax < tmin)) edge_ok = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Normal axis, stages 2..5 in its own unit; sep is read at stage 5.
  // ---------------------------------------------------------------
  logic nrm_sep;

  atot_nrm u_nrm (
    .clk    (clk),
    .e0     (s1_e_r[0]),
    .e1     (s1_e_r[1]),
    .v1     (s1_v_r[1]),
    .box_lo (box_lo_r),
    .box_hi (box_hi_r),
    .sep    (nrm_sep)
  );

  // ---------------------------------------------------------------
  // Verdict and tag travel to stage 5; valid bits for every stage.
  // ---------------------------------------------------------------
  logic           s3_ok_r;
  logic           s4_ok_r;
  logic           s5_ok_r;
  atot_pkg::tag_t s3_tag_r;
  atot_pkg::tag_t s4_tag_r;
  atot_pkg::tag_t s5_tag_r;
  logic [4:0]     vld_r;          // stages 1..5
  logic           out_valid_r;
  atot_pkg::out_word_t out_word_r;

  always_ff @(posedge clk) begin
    s3_ok_r  <= s2_box_ok_r && edge_ok;
    s4_ok_r  <= s3_ok_r;
    s5_ok_r  <= s4_ok_r;
    s3_tag_r <= s2_tag_r;
    s4_tag_r <= s3_tag_r;
    s5_tag_r <= s4_tag_r;
    out_word_r.overlaps   <= s5_ok_r && !nrm_sep;
    out_word_r.result_tag <= s5_tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[3:0], in_accept};
      out_valid_r <= vld_r[4];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  `ATOT_ASSERT_NOW(a_latency, 1'b1, out_valid == $past(in_accept, 6))
  `ATOT_ASSERT_NOW(a_tag_follows, out_valid, out_word.result_tag == $past(in_word.face_tag, 6))
  `ATOT_ASSERT_NOW(a_box_reject, out_valid && out_word.overlaps, $past(s1_box_ok_r, 5))
  `ATOT_ASSERT_NEXT(a_early_reject, vld_r[4] && !s5_ok_r, out_valid && !out_word.overlaps)

endmodule

/* hw/rtl/atot_nrm.sv */
// Triangle-normal axis: normal build, split wide products, span compare.
module atot_nrm (
  input  logic             clk,
  input  atot_pkg::edge_t  e0 [3],
  input  atot_pkg::edge_t  e1 [3],
  input  atot_pkg::coord_t v1 [3],
  input  atot_pkg::coord_t box_lo [3],
  input  atot_pkg::coord_t box_hi [3],
  output logic             sep
);

  atot_pkg::nprod_t s2_pa_r [3];
  atot_pkg::nprod_t s2_pb_r [3];
  atot_pkg::coord_t s2_v_r  [3];
  atot_pkg::nrm_t   s3_n_r  [3];
  atot_pkg::coord_t s3_v_r  [3];
  atot_pkg::nlo_t   s4_lo_r [3][3];   // [component][lo, hi, vertex]
  atot_pkg::nhi_t   s4_hi_r [3][3];
  atot_pkg::nfull_t s5_f_r  [3][3];

  // n = e1 x e0, same axis as (v0-v1) x (v2-v1)
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      s2_pa_r[c] <= atot_pkg::mul_ee(e1[atot_pkg::AX_A[c]], e0[atot_pkg::AX_B[c]]);
      s2_pb_r[c] <= atot_pkg::mul_ee(e1[atot_pkg::AX_B[c]], e0[atot_pkg::AX_A[c]]);
      s2_v_r[c]  <= v1[c];
      s3_n_r[c]  <= atot_pkg::nrm_t'(s2_pa_r[c]) - atot_pkg::nrm_t'(s2_pb_r[c]);
      s3_v_r[c]  <= s2_v_r[c];
    end
  end

  // wide product split: n = hi * 2^NL + lo
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      for (int q = 0; q < 3; q++) begin
        s4_lo_r[c][q] <= atot_pkg::nlo_t'($signed({1'b0, s3_n_r[c][atot_pkg::NL-1:0]}))
                         * atot_pkg::nlo_t'(q == 0 ? box_lo[c] :
                                            q == 1 ? box_hi[c] : s3_v_r[c]);
        s4_hi_r[c][q] <= atot_pkg::nhi_t'($signed(s3_n_r[c][atot_pkg::NW-1:atot_pkg::NL]))
                         * atot_pkg::nhi_t'(q == 0 ? box_lo[c] :
                                            q == 1 ? box_hi[c] : s3_v_r[c]);
        s5_f_r[c][q]  <= (atot_pkg::nfull_t'(s4_hi_r[c][q]) <<< atot_pkg::NL)
                         + atot_pkg::nfull_t'(s4_lo_r[c][q]);
      end
    end
  end

  atot_pkg::nsum_t tri_p;
  atot_pkg::nsum_t bmin;
  atot_pkg::nsum_t bmax;

  // all three vertices project to the same value on the normal
  always_comb begin
    tri_p = '0;
    bmin  = '0;
    bmax  = '0;
    for (int c = 0; c < 3; c++) begin
      tri_p = tri_p + atot_pkg::nsum_t'(s5_f_r[c][2]);
      if (s5_f_r[c][0] < s5_f_r[c][1]) begin
        bmin = bmin + atot_pkg::nsum_t'(s5_f_r[c][0]);
        bmax = bmax + atot_pkg::nsum_t'(s5_f_r[c][1]);
      end else begin
        bmin = bmin + atot_pkg::nsum_t'(s5_f_r[c][1]);
        bmax = bmax + atot_pkg::nsum_t'(s5_f_r[c][0]);
      end
    end
    sep = (tri_p < bmin) || (bmax < tri_p);
  end

endmodule
